[hw/rtl/lcs_rl_pkg.sv]
// ----------------------------------------------------------------------------
// lcs_rl_pkg
// Shared codes, field widths and result layout of the ROUGE-L score unit.
// ----------------------------------------------------------------------------
package lcs_rl_pkg;

   // request kinds carried on req_tuser
   localparam int unsigned REQ_W = 2;
   localparam logic [REQ_W-1:0] REQ_REF_APPEND  = 2'd0;
   localparam logic [REQ_W-1:0] REQ_CAND_APPEND = 2'd1;
   localparam logic [REQ_W-1:0] REQ_COMPUTE     = 2'd2;

   // metric select register codes
   localparam int unsigned METRIC_W = 2;
   localparam logic [METRIC_W-1:0] METRIC_F_MEASURE = 2'd0;
   localparam logic [METRIC_W-1:0] METRIC_RECALL    = 2'd1;
   localparam logic [METRIC_W-1:0] METRIC_PRECISION = 2'd2;

   // result fields, packed from bit 0 up
   localparam int unsigned LEN_W       = 9;
   localparam int unsigned SCORE_W     = 17;
   localparam int unsigned LCS_LSB     = 0;
   localparam int unsigned REF_LSB     = LCS_LSB + LEN_W;
   localparam int unsigned CAND_LSB    = REF_LSB + LEN_W;
   localparam int unsigned SCORE_LSB   = CAND_LSB + LEN_W;
   localparam int unsigned OVF_LSB     = SCORE_LSB + SCORE_W;
   localparam int unsigned RSP_FIELD_W = OVF_LSB + 1;
   localparam int unsigned RSP_TDATA_W = ((RSP_FIELD_W + 7) / 8) * 8;

   // Q1.16 score: 65536 is 1.0
   localparam logic [SCORE_W-1:0] SCORE_ONE = 17'd65536;

   // one quotient bit per divider step
   localparam int unsigned DIV_STEPS = SCORE_W;
   localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS + 1);

endpackage

[hw/rtl/lcs_rouge_l_score_unit.sv]
// ----------------------------------------------------------------------------
// lcs_rouge_l_score_unit
// An append transfer leaves the unit idle, so the next request can be taken
// in the following cycle. A compute transfer fills the LCS table one cell per
// cycle, with a row setup step before each row (the table is skipped when either
// count is zero), then runs 3 multiplier steps, 1 setup, 17 divider steps and an
// output step that holds while an earlier result still waits on rsp_tready.
// Synchronous active-high reset clears counts, overflow, metric and rsp_tvalid.
// ----------------------------------------------------------------------------
module lcs_rouge_l_score_unit #(
   parameter int unsigned MAX_TOKENS = 256,
   parameter int unsigned TOKEN_BITS = 32,
   localparam int unsigned REQ_TDATA_W = ((TOKEN_BITS + 7) / 8) * 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // configuration
   input  logic                                   csr_wr_en,
   input  logic [lcs_rl_pkg::METRIC_W-1:0]        csr_wr_data,   // metric_select
   // request stream
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [REQ_TDATA_W-1:0]                 req_tdata,     // token_id
   input  logic [lcs_rl_pkg::REQ_W-1:0]           req_tuser,     // req_type
   // response stream
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // lcs_len, reference_length, candidate_length, score, overflow
   output logic [lcs_rl_pkg::RSP_TDATA_W-1:0]     rsp_tdata
);

   localparam int unsigned CNT_W   = $clog2(MAX_TOKENS + 1);
   localparam int unsigned AW      = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;
   localparam int unsigned MUL_W   = CNT_W + 1;
   localparam int unsigned PROD_W  = 2 * CNT_W;
   localparam int unsigned REM_W   = 2 * CNT_W + 2;
   localparam int unsigned LEN_W   = lcs_rl_pkg::LEN_W;
   localparam int unsigned SCORE_W = lcs_rl_pkg::SCORE_W;
   localparam int unsigned DCW     = lcs_rl_pkg::DIV_CNT_W;
   localparam int unsigned PAD_W   = lcs_rl_pkg::RSP_TDATA_W - lcs_rl_pkg::RSP_FIELD_W;

   typedef enum logic [3:0] {
      S_IDLE, S_ROW, S_CELL, S_MUL_RC, S_MUL_LS, S_MUL_LL, S_SETUP, S_DIV, S_FINISH
   } state_type;

   state_type                      state_ff;
   logic [lcs_rl_pkg::METRIC_W-1:0] metric_ff;
   logic [CNT_W-1:0]               ref_cnt_ff, cand_cnt_ff;
   logic                           dropped_ff;
   logic [CNT_W-1:0]               i_ff, jc_ff;
   logic [CNT_W-1:0]               left_ff, diag_ff, lcs_ff;
   logic [CNT_W-1:0]               r_ff, c_ff;
   logic [PROD_W-1:0]              rc_ff, ll_ff;
   logic [PROD_W:0]                ls_ff;
   logic [REM_W-1:0]               rem_ff;
   logic [PROD_W-1:0]              den_ff;
   logic [SCORE_W-1:0]             quot_ff;
   logic [DCW-1:0]                 div_cnt_ff;
   logic                           rsp_valid_ff;
   logic [lcs_rl_pkg::RSP_TDATA_W-1:0] rsp_data_ff;

   // memories and their registered read data
   logic [TOKEN_BITS-1:0] ref_mem  [MAX_TOKENS];
   logic [TOKEN_BITS-1:0] cand_mem [MAX_TOKENS];
   logic [CNT_W-1:0]      dp_mem   [MAX_TOKENS + 1];
   logic [TOKEN_BITS-1:0] ref_tok_ff, cand_rd_ff;
   logic [CNT_W-1:0]      dp_rd_ff;

   logic                  req_xfer, ref_wr_en, cand_wr_en, rd_en, dp_wr_en;
   logic [TOKEN_BITS-1:0] tok;
   logic [CNT_W-1:0]      dp_raddr;
   logic [AW-1:0]         cand_raddr;
   logic [CNT_W-1:0]      up, val_in;
   logic [MUL_W-1:0]      mul_a, mul_b;
   logic [REM_W-1:0]      mul_p;
   logic [REM_W-1:0]      num_in, diff, rem_in;
   logic [PROD_W-1:0]     den_in;
   logic                  ge;

   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign tok        = req_tdata[TOKEN_BITS-1:0];
   assign ref_wr_en  = req_xfer && (req_tuser == lcs_rl_pkg::REQ_REF_APPEND)
                       && (ref_cnt_ff < CNT_W'(MAX_TOKENS));
   assign cand_wr_en = req_xfer && (req_tuser == lcs_rl_pkg::REQ_CAND_APPEND)
                       && (cand_cnt_ff < CNT_W'(MAX_TOKENS));

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // table cell: left is the cell just produced, diag the previous up
   always_comb begin
      rd_en      = (state_ff == S_ROW) || ((state_ff == S_CELL) && (jc_ff < cand_cnt_ff));
      dp_wr_en   = (state_ff == S_CELL);
      dp_raddr   = (state_ff == S_ROW) ? CNT_W'(1) : jc_ff + CNT_W'(1);
      cand_raddr = (state_ff == S_ROW) ? AW'(0) : jc_ff[AW-1:0];
      // first row sees an all-zero row above it
      up         = (i_ff == '0) ? '0 : dp_rd_ff;
      if (ref_tok_ff == cand_rd_ff) begin
         val_in = diag_ff + CNT_W'(1);
      end else begin
         val_in = (up > left_ff) ? up : left_ff;
      end
   end

   // shared multiplier
   always_comb begin
      case (state_ff)
         S_MUL_RC: begin
            mul_a = MUL_W'(r_ff);
            mul_b = MUL_W'(c_ff);
         end
         S_MUL_LS: begin
            mul_a = MUL_W'(lcs_ff);
            mul_b = MUL_W'(r_ff) + MUL_W'(c_ff);
         end
         S_MUL_LL: begin
            mul_a = MUL_W'(lcs_ff);
            mul_b = MUL_W'(lcs_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_p = mul_a * mul_b;
   end

   // dividend and divisor of the selected ratio
   always_comb begin
      case (metric_ff)
         lcs_rl_pkg::METRIC_F_MEASURE: begin
            if (ls_ff >= {1'b0, rc_ff}) begin
               num_in = REM_W'(lcs_ff) << 1;
               den_in = PROD_W'(r_ff) + PROD_W'(c_ff);
            end else begin
               num_in = REM_W'(ll_ff) << 1;
               den_in = rc_ff;
            end
         end
         lcs_rl_pkg::METRIC_RECALL: begin
            num_in = REM_W'(lcs_ff);
            den_in = PROD_W'(r_ff);
         end
         lcs_rl_pkg::METRIC_PRECISION: begin
            num_in = REM_W'(lcs_ff);
            den_in = PROD_W'(c_ff);
         end
         default: begin
            num_in = '0;
            den_in = PROD_W'(1);
         end
      endcase
   end

   // restoring fraction divider, one quotient bit per step
   always_comb begin
      ge     = (rem_ff >= REM_W'(den_ff));
      diff   = rem_ff - REM_W'(den_ff);
      rem_in = ge ? {diff[REM_W-2:0], 1'b0} : {rem_ff[REM_W-2:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (ref_wr_en) begin
         ref_mem[ref_cnt_ff[AW-1:0]] <= tok;
      end
      if (state_ff == S_ROW) begin
         ref_tok_ff <= ref_mem[i_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cand_wr_en) begin
         cand_mem[cand_cnt_ff[AW-1:0]] <= tok;
      end
      if (rd_en) begin
         cand_rd_ff <= cand_mem[cand_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (dp_wr_en) begin
         dp_mem[jc_ff] <= val_in;
      end
      if (rd_en) begin
         dp_rd_ff <= dp_mem[dp_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         metric_ff    <= lcs_rl_pkg::METRIC_F_MEASURE;
         ref_cnt_ff   <= '0;
         cand_cnt_ff  <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            metric_ff <= csr_wr_data;
         end
         // the output cycle refills the register itself
         if (rsp_valid_ff && rsp_tready && (state_ff != S_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_xfer) begin
                  case (req_tuser)
                     lcs_rl_pkg::REQ_REF_APPEND: begin
                        if (ref_wr_en) begin
                           ref_cnt_ff <= ref_cnt_ff + CNT_W'(1);
                        end else begin
                           dropped_ff <= 1'b1;
                        end
                     end
                     lcs_rl_pkg::REQ_CAND_APPEND: begin
                        if (cand_wr_en) begin
                           cand_cnt_ff <= cand_cnt_ff + CNT_W'(1);
                        end else begin
                           dropped_ff <= 1'b1;
                        end
                     end
                     lcs_rl_pkg::REQ_COMPUTE: begin
                        i_ff   <= '0;
                        r_ff   <= (ref_cnt_ff == '0) ? CNT_W'(1) : ref_cnt_ff;
                        c_ff   <= (cand_cnt_ff == '0) ? CNT_W'(1) : cand_cnt_ff;
                        lcs_ff <= '0;
                        if ((ref_cnt_ff == '0) || (cand_cnt_ff == '0)) begin
                           state_ff <= S_MUL_RC;
                        end else begin
                           state_ff <= S_ROW;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            S_ROW: begin
               left_ff  <= '0;
               diag_ff  <= '0;
               jc_ff    <= CNT_W'(1);
               state_ff <= S_CELL;
            end
            S_CELL: begin
               left_ff <= val_in;
               diag_ff <= up;
               if (jc_ff == cand_cnt_ff) begin
                  if (i_ff == ref_cnt_ff - CNT_W'(1)) begin
                     lcs_ff   <= val_in;
                     state_ff <= S_MUL_RC;
                  end else begin
                     i_ff     <= i_ff + CNT_W'(1);
                     state_ff <= S_ROW;
                  end
               end else begin
                  jc_ff <= jc_ff + CNT_W'(1);
               end
            end
            S_MUL_RC: begin
               rc_ff    <= mul_p[PROD_W-1:0];
               state_ff <= S_MUL_LS;
            end
            S_MUL_LS: begin
               ls_ff    <= mul_p[PROD_W:0];
               state_ff <= S_MUL_LL;
            end
            S_MUL_LL: begin
               ll_ff    <= mul_p[PROD_W-1:0];
               state_ff <= S_SETUP;
            end
            S_SETUP: begin
               rem_ff     <= num_in;
               den_ff     <= den_in;
               quot_ff    <= '0;
               div_cnt_ff <= '0;
               state_ff   <= S_DIV;
            end
            S_DIV: begin
               rem_ff     <= rem_in;
               quot_ff    <= {quot_ff[SCORE_W-2:0], ge};
               div_cnt_ff <= div_cnt_ff + DCW'(1);
               if (div_cnt_ff == DCW'(lcs_rl_pkg::DIV_STEPS - 1)) begin
                  state_ff <= S_FINISH;
               end
            end
            S_FINISH: begin
               // hold the result until the output register is free
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_data_ff  <= {{PAD_W{1'b0}}, dropped_ff, quot_ff,
                                   LEN_W'(cand_cnt_ff), LEN_W'(ref_cnt_ff), LEN_W'(lcs_ff)};
                  rsp_valid_ff <= 1'b1;
                  ref_cnt_ff   <= '0;
                  cand_cnt_ff  <= '0;
                  dropped_ff   <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

[hw/rtl/lcs_rl_checker.sv]
// ----------------------------------------------------------------------------
// lcs_rl_checker
// Port-level checks of the ROUGE-L score unit, bound to the top level.
// ----------------------------------------------------------------------------
module lcs_rl_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic [lcs_rl_pkg::REQ_W-1:0]       req_tuser,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [lcs_rl_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int unsigned LEN_W   = lcs_rl_pkg::LEN_W;
   localparam int unsigned SCORE_W = lcs_rl_pkg::SCORE_W;

   logic [LEN_W-1:0]   lcs_len, ref_len, cand_len;
   logic [SCORE_W-1:0] score;

   assign lcs_len  = rsp_tdata[lcs_rl_pkg::LCS_LSB  +: LEN_W];
   assign ref_len  = rsp_tdata[lcs_rl_pkg::REF_LSB  +: LEN_W];
   assign cand_len = rsp_tdata[lcs_rl_pkg::CAND_LSB +: LEN_W];
   assign score    = rsp_tdata[lcs_rl_pkg::SCORE_LSB +: SCORE_W];

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // a compute transfer busies the block
   a_compute_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == lcs_rl_pkg::REQ_COMPUTE) |=> !req_tready)
      else $error("ready right after compute transfer");

   a_lcs_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (lcs_len <= ref_len) && (lcs_len <= cand_len))
      else $error("lcs length exceeds a sequence length");

   a_score_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (score <= lcs_rl_pkg::SCORE_ONE))
      else $error("score above one");

endmodule

bind lcs_rouge_l_score_unit lcs_rl_checker u_lcs_rl_checker (.*);

[dv/tb_lcs_rouge_l_score_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lcs_rouge_l_score_unit
// Streams reference and candidate tokens into the ROUGE-L score unit and
// closes most frames with a compute request. A scoreboard class keeps its own
// token stores, computes the LCS and the Q1.16 score for every compute
// transfer, and checks each response field by field. The sender works in
// bursts and the receiver stalls on its own pattern. Each metric setting is
// written while the unit is idle.
// ----------------------------------------------------------------------------

typedef struct packed {
   logic [lcs_rl_pkg::LEN_W-1:0]   lcs;
   logic [lcs_rl_pkg::LEN_W-1:0]   ref_len;
   logic [lcs_rl_pkg::LEN_W-1:0]   cand_len;
   logic [lcs_rl_pkg::SCORE_W-1:0] score;
   logic                           overflow;
} rouge_result_type;

class lcs_score_model;
   localparam int unsigned STORE_DEPTH = 256;
   localparam int unsigned PEND_DEPTH = 8;

   logic [31:0]                     ref_tok [STORE_DEPTH];
   logic [31:0]                     cand_tok [STORE_DEPTH];
   int unsigned                     ref_cnt = 0;
   int unsigned                     cand_cnt = 0;
   bit                              dropped = 0;
   logic [lcs_rl_pkg::METRIC_W-1:0] metric = lcs_rl_pkg::METRIC_F_MEASURE;
   rouge_result_type                expected_scores [PEND_DEPTH];
   int unsigned                     wr_ptr = 0;
   int unsigned                     rd_ptr = 0;
   int unsigned                     mismatches = 0;

   function void set_metric(logic [lcs_rl_pkg::METRIC_W-1:0] m);
      metric = m;
   endfunction

   function int unsigned pending();
      return wr_ptr - rd_ptr;
   endfunction

   // lcs over one dp row, then the selected ratio truncated to q1.16
   function rouge_result_type score_pair();
      int unsigned      row [0:STORE_DEPTH];
      int unsigned      diag;
      int unsigned      up;
      int unsigned      cell_val;
      longint unsigned  l;
      longint unsigned  r;
      longint unsigned  c;
      longint unsigned  q;
      rouge_result_type res;
      for (int j = 0; j <= cand_cnt; j++) row[j] = 0;
      for (int i = 0; i < ref_cnt; i++) begin
         diag = 0;
         for (int j = 1; j <= cand_cnt; j++) begin
            up = row[j];
            if (ref_tok[i] == cand_tok[j-1]) begin
               cell_val = diag + 1;
            end else begin
               cell_val = (up > row[j-1]) ? up : row[j-1];
            end
            diag = up;
            row[j] = cell_val;
         end
      end
      l = row[cand_cnt];
      r = (ref_cnt == 0) ? 1 : ref_cnt;
      c = (cand_cnt == 0) ? 1 : cand_cnt;
      case (metric)
         lcs_rl_pkg::METRIC_F_MEASURE: begin
            // p+r below 1.0 keeps the 2pr form
            if (l * (r + c) >= r * c) q = (2 * l * lcs_rl_pkg::SCORE_ONE) / (r + c);
            else q = (2 * l * l * lcs_rl_pkg::SCORE_ONE) / (r * c);
         end
         lcs_rl_pkg::METRIC_RECALL:    q = (l * lcs_rl_pkg::SCORE_ONE) / r;
         lcs_rl_pkg::METRIC_PRECISION: q = (l * lcs_rl_pkg::SCORE_ONE) / c;
         default:                      q = 0;
      endcase
      res.lcs      = l[lcs_rl_pkg::LEN_W-1:0];
      res.ref_len  = ref_cnt[lcs_rl_pkg::LEN_W-1:0];
      res.cand_len = cand_cnt[lcs_rl_pkg::LEN_W-1:0];
      res.score    = q[lcs_rl_pkg::SCORE_W-1:0];
      res.overflow = dropped;
      return res;
   endfunction

   function void note_request(logic [lcs_rl_pkg::REQ_W-1:0] kind, logic [31:0] token);
      if (kind == lcs_rl_pkg::REQ_REF_APPEND) begin
         if (ref_cnt < STORE_DEPTH) begin
            ref_tok[ref_cnt] = token;
            ref_cnt++;
         end else begin
            dropped = 1;
         end
      end else if (kind == lcs_rl_pkg::REQ_CAND_APPEND) begin
         if (cand_cnt < STORE_DEPTH) begin
            cand_tok[cand_cnt] = token;
            cand_cnt++;
         end else begin
            dropped = 1;
         end
      end else if (kind == lcs_rl_pkg::REQ_COMPUTE) begin
         if (pending() >= PEND_DEPTH) begin
            mismatches++;
            $display("%0t: pending results expected below %0d got %0d", $time,
                     PEND_DEPTH, pending());
         end else begin
            expected_scores[wr_ptr % PEND_DEPTH] = score_pair();
            wr_ptr++;
         end
         ref_cnt = 0;
         cand_cnt = 0;
         dropped = 0;
      end
   endfunction

   function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      end
   endfunction

   function void check_response(logic [lcs_rl_pkg::RSP_TDATA_W-1:0] data);
      rouge_result_type want;
      if (pending() == 0) begin
         mismatches++;
         $display("%0t: response expected none got %h", $time, data);
         return;
      end
      want = expected_scores[rd_ptr % PEND_DEPTH];
      rd_ptr++;
      compare_field("lcs_len", want.lcs,
                    data[lcs_rl_pkg::LCS_LSB +: lcs_rl_pkg::LEN_W]);
      compare_field("reference_length", want.ref_len,
                    data[lcs_rl_pkg::REF_LSB +: lcs_rl_pkg::LEN_W]);
      compare_field("candidate_length", want.cand_len,
                    data[lcs_rl_pkg::CAND_LSB +: lcs_rl_pkg::LEN_W]);
      compare_field("score", want.score,
                    data[lcs_rl_pkg::SCORE_LSB +: lcs_rl_pkg::SCORE_W]);
      compare_field("overflow", want.overflow, data[lcs_rl_pkg::OVF_LSB]);
   endfunction
endclass

module tb_lcs_rouge_l_score_unit;
   localparam logic [lcs_rl_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
   localparam logic [lcs_rl_pkg::METRIC_W-1:0] METRIC_UNUSED = 2'd3;
   localparam int unsigned CYCLE_LIMIT = 2_000_000;
   localparam int unsigned IDLE_SETTLE = 40;
   localparam int unsigned ITEMS_PER_PHASE = 200;
   localparam int unsigned NUM_PHASES = 8;

   typedef enum logic [1:0] {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_PERIODIC} ready_mode_type;

   logic                                 clock;
   logic                                 reset = 1'b1;
   logic                                 csr_wr_en = 1'b0;
   logic [lcs_rl_pkg::METRIC_W-1:0]      csr_wr_data = '0;
   logic                                 req_tvalid = 1'b0;
   logic                                 req_tready;
   logic [31:0]                          req_tdata = '0;    // token_id
   logic [lcs_rl_pkg::REQ_W-1:0]         req_tuser = '0;    // req_type
   logic                                 rsp_tvalid;
   logic                                 rsp_tready = 1'b0;
   // lcs_len, reference_length, candidate_length, score, overflow
   logic [lcs_rl_pkg::RSP_TDATA_W-1:0]   rsp_tdata;

   lcs_score_model            score_model = new;
   int unsigned               items_sent = 0;
   int unsigned               burst_left = 0;
   bit                        steady_mode = 0;
   int unsigned               cycle_count = 0;
   ready_mode_type            ready_mode = RDY_ALWAYS;
   int unsigned               mode_left = 0;

   lcs_rouge_l_score_unit dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // receiver: picks a new random stall pattern whenever the current one runs out
   always @(posedge clock) begin
      if (mode_left == 0) begin
         ready_mode <= ready_mode_type'($urandom_range(0, 3));
         mode_left <= $urandom_range(32, 400);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (ready_mode)
         RDY_ALWAYS:   rsp_tready <= 1'b1;
         RDY_COIN:     rsp_tready <= 1'($urandom_range(0, 1));
         RDY_SPARSE:   rsp_tready <= ($urandom_range(0, 7) == 0);
         default:      rsp_tready <= (mode_left[3:0] < 4);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) score_model.note_request(req_tuser, req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) score_model.check_response(rsp_tdata);
   end

   task automatic send_item(input logic [lcs_rl_pkg::REQ_W-1:0] kind,
                            input logic [31:0] token);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = steady_mode ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= token;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (kind != REQ_UNUSED) items_sent++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (score_model.pending() != 0) @(posedge clock);
      repeat (IDLE_SETTLE) @(posedge clock);
   endtask

   task automatic write_metric(input logic [lcs_rl_pkg::METRIC_W-1:0] m);
      csr_wr_en <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      score_model.set_metric(m);
   endtask

   // tokens share a random base so all bits toggle while matches stay likely
   task automatic send_token_frame(input int unsigned n_ref, input int unsigned n_cand,
                                   input int unsigned alpha, input bit same_seq,
                                   input bit close_frame);
      logic [31:0] base;
      int unsigned ri;
      int unsigned ci;
      base = $urandom;
      ri = 0;
      ci = 0;
      while (ri < n_ref || ci < n_cand) begin
         if ($urandom_range(0, 31) == 0) send_item(REQ_UNUSED, $urandom);
         if (ci >= n_cand || (ri < n_ref && $urandom_range(0, 1) == 1)) begin
            send_item(lcs_rl_pkg::REQ_REF_APPEND,
                      same_seq ? base ^ ri : base ^ $urandom_range(0, alpha));
            ri++;
         end else begin
            send_item(lcs_rl_pkg::REQ_CAND_APPEND,
                      same_seq ? base ^ ci : base ^ $urandom_range(0, alpha));
            ci++;
         end
      end
      if (close_frame) send_item(lcs_rl_pkg::REQ_COMPUTE, $urandom);
   endtask

   task automatic send_random_frame();
      int unsigned n_ref;
      int unsigned n_cand;
      int unsigned alpha;
      case ($urandom_range(0, 9))
         0: begin
            n_ref = $urandom_range(0, 2);
            n_cand = $urandom_range(0, 2);
         end
         8: begin
            n_ref = $urandom_range(13, 40);
            n_cand = $urandom_range(13, 40);
         end
         9: begin
            n_ref = $urandom_range(0, 1) ? 0 : $urandom_range(1, 12);
            n_cand = (n_ref != 0) ? 0 : $urandom_range(0, 12);
         end
         default: begin
            n_ref = $urandom_range(1, 12);
            n_cand = $urandom_range(1, 12);
         end
      endcase
      alpha = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF : (1 << $urandom_range(0, 5)) - 1;
      send_token_frame(n_ref, n_cand, alpha, $urandom_range(0, 9) == 0,
                       $urandom_range(0, 9) != 0);
   endtask

   initial begin
      logic [lcs_rl_pkg::METRIC_W-1:0] phase_metric [NUM_PHASES];
      phase_metric = '{lcs_rl_pkg::METRIC_RECALL, lcs_rl_pkg::METRIC_PRECISION,
                       METRIC_UNUSED, lcs_rl_pkg::METRIC_F_MEASURE,
                       lcs_rl_pkg::METRIC_PRECISION, lcs_rl_pkg::METRIC_RECALL,
                       lcs_rl_pkg::METRIC_F_MEASURE, METRIC_UNUSED};
      phase_metric[NUM_PHASES-1] = lcs_rl_pkg::METRIC_W'($urandom_range(0, 3));

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: f measure out of reset
      send_item(lcs_rl_pkg::REQ_COMPUTE, 32'h0);
      send_item(lcs_rl_pkg::REQ_REF_APPEND, 32'h0000_0000);
      send_item(lcs_rl_pkg::REQ_REF_APPEND, 32'hFFFF_FFFF);
      send_item(lcs_rl_pkg::REQ_REF_APPEND, 32'hA5A5_A5A5);
      send_item(lcs_rl_pkg::REQ_CAND_APPEND, 32'hFFFF_FFFF);
      send_item(lcs_rl_pkg::REQ_CAND_APPEND, 32'h0000_0000);
      send_item(lcs_rl_pkg::REQ_COMPUTE, 32'hFFFF_FFFF);
      // unused request kind, then a compute with an empty candidate
      send_item(REQ_UNUSED, 32'h1234_5678);
      send_item(lcs_rl_pkg::REQ_REF_APPEND, 32'h0000_0001);
      send_item(lcs_rl_pkg::REQ_REF_APPEND, 32'h0000_0002);
      send_item(lcs_rl_pkg::REQ_COMPUTE, 32'h0);
      // identical sequences give a score of one
      for (int k = 1; k <= 3; k++) send_item(lcs_rl_pkg::REQ_REF_APPEND, k);
      for (int k = 1; k <= 3; k++) send_item(lcs_rl_pkg::REQ_CAND_APPEND, k);
      send_item(lcs_rl_pkg::REQ_COMPUTE, 32'h0);
      // weak overlap where p+r stays below one
      for (int k = 7; k <= 10; k++) send_item(lcs_rl_pkg::REQ_REF_APPEND, k);
      send_item(lcs_rl_pkg::REQ_CAND_APPEND, 32'd7);
      for (int k = 11; k <= 13; k++) send_item(lcs_rl_pkg::REQ_CAND_APPEND, k);
      send_item(lcs_rl_pkg::REQ_COMPUTE, 32'h0);
      wait_idle();

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         steady_mode = (phase % 3 == 1);
         write_metric(phase_metric[phase]);
         // full stores: one drops reference tokens, one drops candidate tokens
         if (phase == 2) send_token_frame(258, 256, 0, 1, 1);
         if (phase == 5) send_token_frame(256, 260, 3, 0, 1);
         while (items_sent < (phase + 1) * ITEMS_PER_PHASE) send_random_frame();
         send_item(lcs_rl_pkg::REQ_COMPUTE, $urandom);
         wait_idle();
      end

      if (score_model.mismatches == 0 && score_model.pending() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

[files.f]
hw/rtl/lcs_rl_pkg.sv
hw/rtl/lcs_rouge_l_score_unit.sv
hw/rtl/lcs_rl_checker.sv
dv/tb_lcs_rouge_l_score_unit.sv
